### design/fpec_pkg.sv
// shared constants, command codes and controller/datapath interface structs
// for the flash program/erase controller; no dependencies
package fpec_pkg;

  localparam int MAIN_BYTES_DEF   = 1024;
  localparam int MAIN_SEGMENT_DEF = 512;
  localparam int INFO_BYTES_DEF   = 256;
  localparam int INFO_SEGMENT_DEF = 128;

  localparam int CMD_W  = 2;
  localparam int OFF_W  = 10;
  localparam int DATA_W = 16;
  localparam int SIZE_W = 2;
  localparam int BYTE_W = 8;
  localparam int EXT_W  = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_REG_WR = 2'd0,
    CMD_REG_RD = 2'd1,
    CMD_MEM_WR = 2'd2,
    CMD_MEM_RD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERASE_NONE = 2'd0,
    ERASE_SEG  = 2'd1,
    ERASE_MAIN = 2'd2,
    ERASE_ALL  = 2'd3
  } erase_t;

  localparam logic [OFF_W-2:0]  REG_CTL1 = (OFF_W-1)'(0);
  localparam logic [OFF_W-2:0]  REG_CTL2 = (OFF_W-1)'(1);
  localparam logic [OFF_W-2:0]  REG_CTL3 = (OFF_W-1)'(2);

  localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_TWO = SIZE_W'(2);

  localparam logic [DATA_W-1:0] CTL1_MASK  = 16'hFFC6;
  localparam logic [DATA_W-1:0] CTL2_MASK  = 16'hFFFF;
  localparam logic [DATA_W-1:0] CTL3_MASK  = 16'hFF37;
  localparam logic [DATA_W-1:0] CTL1_RESET = 16'h9600;
  localparam logic [DATA_W-1:0] CTL2_RESET = 16'h9642;
  localparam logic [DATA_W-1:0] CTL3_RESET = 16'h9618;
  localparam int                LOCK_POS   = 4;
  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  typedef struct packed {
    logic latch;
    logic seek_init;
    logic seek_step;
    logic sweep_seg_init;
    logic sweep_all_init;
    logic sweep_step;
    logic seg_wr;
    logic all_wr;
    logic rd0;
    logic proc0;
    logic proc1;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   lock;
    erase_t erase;
    logic   prog;
    logic   off_ok;
    logic   two;
    logic   seek_more;
    logic   seg_last;
    logic   all_last;
    logic   out_free;
  } dp_stat_t;

endpackage

### design/flash_program_erase_controller.sv
// sequence: register access or no-op write goes from dispatch straight to the result;
// memory read or program handles one or two bytes; segment erase seeks past the preceding
// segments, then erases its bytes; main or full erase sweeps max(MAIN_BYTES, INFO_BYTES) addresses
// transactions: one at a time; next accept in the cycle after the result loads
// reset: clearing pass writes 0xFF over both arrays, one address per cycle, sweeping
// max(MAIN_BYTES, INFO_BYTES) addresses, in_ready low throughout
module flash_program_erase_controller
  import fpec_pkg::*;
#(
  parameter int MAIN_BYTES   = MAIN_BYTES_DEF,
  parameter int MAIN_SEGMENT = MAIN_SEGMENT_DEF,
  parameter int INFO_BYTES   = INFO_BYTES_DEF,
  parameter int INFO_SEGMENT = INFO_SEGMENT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic              in_region,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic [DATA_W-1:0] in_data,
  input  logic [SIZE_W-1:0] in_access_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  fpec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  fpec_datapath #(
    .MAIN_BYTES   (MAIN_BYTES),
    .MAIN_SEGMENT (MAIN_SEGMENT),
    .INFO_BYTES   (INFO_BYTES),
    .INFO_SEGMENT (INFO_SEGMENT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dcmd           (dcmd),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_region      (in_region),
    .in_offset      (in_offset),
    .in_data        (in_data),
    .in_access_size (in_access_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data)
  );

endmodule

### design/fpec_store.sv
// byte-wide flash array, one write port and one registered read port
// no package dependencies
module fpec_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/fpec_datapath.sv
// datapath: transaction fields, control registers, both flash arrays,
// sweep and segment counters, output register; uses fpec_pkg and fpec_store
module fpec_datapath
  import fpec_pkg::*;
#(
  parameter int MAIN_BYTES   = MAIN_BYTES_DEF,
  parameter int MAIN_SEGMENT = MAIN_SEGMENT_DEF,
  parameter int INFO_BYTES   = INFO_BYTES_DEF,
  parameter int INFO_SEGMENT = INFO_SEGMENT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           dcmd,
  output dp_stat_t          stat,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic              in_region,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic [DATA_W-1:0] in_data,
  input  logic [SIZE_W-1:0] in_access_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data
);

  localparam int MAW = $clog2(MAIN_BYTES);
  localparam int IAW = $clog2(INFO_BYTES);
  localparam int ALL_BYTES = (MAIN_BYTES > INFO_BYTES) ? MAIN_BYTES : INFO_BYTES;
  localparam logic [EXT_W-1:0] MAIN_LIM = EXT_W'(MAIN_BYTES);
  localparam logic [EXT_W-1:0] INFO_LIM = EXT_W'(INFO_BYTES);
  localparam logic [EXT_W-1:0] MAIN_SEG = EXT_W'(MAIN_SEGMENT);
  localparam logic [EXT_W-1:0] INFO_SEG = EXT_W'(INFO_SEGMENT);
  localparam logic [EXT_W-1:0] ALL_LIM  = EXT_W'(ALL_BYTES);
  localparam logic [EXT_W-1:0] ONE      = EXT_W'(1);

  cmd_t               cmd_r;
  logic               region_r;
  logic [OFF_W-1:0]   off_r;
  logic [DATA_W-1:0]  data_r;
  logic [SIZE_W-1:0]  size_r;
  logic [DATA_W-1:0]  ctl1_r, ctl2_r, ctl3_r;
  logic [EXT_W-1:0]   sweep_r, base_r;
  logic               all_info_r;
  logic [BYTE_W-1:0]  res_lo_r, res_hi_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;

  logic [OFF_W-2:0]   idx;
  logic [EXT_W-1:0]   a0, a1, lim_sel, seg_sel, raddr, waddr, sweep_inc;
  logic               ok0, ok1, ok_cur, prog_wr;
  logic [BYTE_W-1:0]  main_rdata, info_rdata, rdata, byte_val, wbyte, and_byte;
  logic               main_we, info_we;
  logic [DATA_W-1:0]  reg_val, result;

  assign idx       = off_r[OFF_W-1:1];
  assign a0        = {{(EXT_W-OFF_W){1'b0}}, off_r};
  assign a1        = a0 + ONE;
  assign lim_sel   = region_r ? INFO_LIM : MAIN_LIM;
  assign seg_sel   = region_r ? INFO_SEG : MAIN_SEG;
  assign ok0       = a0 < lim_sel;
  assign ok1       = a1 < lim_sel;
  assign sweep_inc = sweep_r + ONE;

  // byte 1 read is issued while byte 0 is processed
  assign raddr  = dcmd.proc0 ? a1 : a0;
  assign rdata  = region_r ? info_rdata : main_rdata;
  assign ok_cur = dcmd.proc1 ? ok1 : ok0;
  assign byte_val = ok_cur ? rdata : '0;
  assign and_byte = dcmd.proc1 ? data_r[DATA_W-1:BYTE_W] : data_r[BYTE_W-1:0];
  assign prog_wr  = (dcmd.proc0 | dcmd.proc1) & ok_cur & (cmd_r == CMD_MEM_WR);

  always_comb begin
    main_we = 1'b0;
    info_we = 1'b0;
    waddr   = sweep_r;
    wbyte   = ERASED_BYTE;
    if (dcmd.seg_wr) begin
      main_we = !region_r;
      info_we = region_r;
    end else if (dcmd.all_wr) begin
      main_we = sweep_r < MAIN_LIM;
      info_we = all_info_r && (sweep_r < INFO_LIM);
    end else if (prog_wr) begin
      main_we = !region_r;
      info_we = region_r;
      waddr   = dcmd.proc1 ? a1 : a0;
      wbyte   = rdata & and_byte;
    end
  end

  fpec_store #(.DEPTH(MAIN_BYTES), .AW(MAW)) u_main (
    .clk   (clk),
    .we    (main_we),
    .waddr (waddr[MAW-1:0]),
    .wdata (wbyte),
    .raddr (raddr[MAW-1:0]),
    .rdata (main_rdata)
  );

  fpec_store #(.DEPTH(INFO_BYTES), .AW(IAW)) u_info (
    .clk   (clk),
    .we    (info_we),
    .waddr (waddr[IAW-1:0]),
    .wdata (wbyte),
    .raddr (raddr[IAW-1:0]),
    .rdata (info_rdata)
  );

  always_comb begin
    if (idx == REG_CTL1) begin
      reg_val = ctl1_r;
    end else if (idx == REG_CTL2) begin
      reg_val = ctl2_r;
    end else if (idx == REG_CTL3) begin
      reg_val = ctl3_r;
    end else begin
      reg_val = '0;
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_REG_RD: result = reg_val;
      CMD_MEM_RD: result = {res_hi_r, res_lo_r};
      default:    result = '0;
    endcase
  end

  // transaction fields, read bytes, segment base and output data
  always_ff @(posedge clk) begin
    if (dcmd.latch) begin
      cmd_r    <= cmd_t'(in_cmd);
      region_r <= in_region;
      off_r    <= in_offset;
      data_r   <= in_data;
      size_r   <= in_access_size;
      res_hi_r <= '0;
    end
    if (dcmd.proc0) begin
      res_lo_r <= byte_val;
    end
    if (dcmd.proc1) begin
      res_hi_r <= byte_val;
    end
    if (dcmd.seek_init) begin
      base_r <= '0;
    end else if (dcmd.seek_step) begin
      base_r <= base_r + seg_sel;
    end
    if (dcmd.finish) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= CTL1_RESET;
      ctl2_r      <= CTL2_RESET;
      ctl3_r      <= CTL3_RESET;
      sweep_r     <= '0;
      all_info_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (dcmd.finish && cmd_r == CMD_REG_WR && size_r == SIZE_TWO) begin
        if (idx == REG_CTL1) begin
          ctl1_r <= data_r & CTL1_MASK;
        end else if (idx == REG_CTL2) begin
          ctl2_r <= data_r & CTL2_MASK;
        end else if (idx == REG_CTL3) begin
          ctl3_r <= data_r & CTL3_MASK;
        end
      end
      if (dcmd.sweep_all_init) begin
        sweep_r    <= '0;
        all_info_r <= (erase_t'(ctl1_r[2:1]) == ERASE_ALL);
      end else if (dcmd.sweep_seg_init) begin
        sweep_r <= base_r;
      end else if (dcmd.sweep_step) begin
        sweep_r <= sweep_inc;
      end
      if (dcmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.lock      = ctl3_r[LOCK_POS];
  assign stat.erase     = erase_t'(ctl1_r[2:1]);
  assign stat.prog      = ctl1_r[6];
  assign stat.off_ok    = ok0;
  assign stat.two       = (size_r != SIZE_ONE);
  assign stat.seek_more = a0 >= (base_r + seg_sel);
  assign stat.seg_last  = (sweep_inc == base_r + seg_sel) || (sweep_inc == lim_sel);
  assign stat.all_last  = (sweep_inc == ALL_LIM);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

### design/fpec_ctrl.sv
// controller state machine: sequences register access, byte read and
// program, segment search and erase sweeps; uses fpec_pkg
module fpec_ctrl
  import fpec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_INIT = 10'b00_0000_0010,
    S_DISP = 10'b00_0000_0100,
    S_RD   = 10'b00_0000_1000,
    S_B0   = 10'b00_0001_0000,
    S_B1   = 10'b00_0010_0000,
    S_SEEK = 10'b00_0100_0000,
    S_SEG  = 10'b00_1000_0000,
    S_ALL  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    dcmd      = '0;
    case (state_r)
      S_INIT: begin
        dcmd.all_wr     = 1'b1;
        dcmd.sweep_step = 1'b1;
        if (stat.all_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          dcmd.latch = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd)
          CMD_MEM_RD: state_nxt = S_RD;
          CMD_MEM_WR: begin
            if (stat.lock) begin
              state_nxt = S_DONE;
            end else begin
              case (stat.erase)
                ERASE_SEG: begin
                  if (stat.off_ok) begin
                    dcmd.seek_init = 1'b1;
                    state_nxt      = S_SEEK;
                  end else begin
                    state_nxt = S_DONE;
                  end
                end
                ERASE_MAIN, ERASE_ALL: begin
                  dcmd.sweep_all_init = 1'b1;
                  state_nxt           = S_ALL;
                end
                default: state_nxt = stat.prog ? S_RD : S_DONE;
              endcase
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RD: begin
        dcmd.rd0  = 1'b1;
        state_nxt = S_B0;
      end
      S_B0: begin
        dcmd.proc0 = 1'b1;
        state_nxt  = stat.two ? S_B1 : S_DONE;
      end
      S_B1: begin
        dcmd.proc1 = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SEEK: begin
        if (stat.seek_more) begin
          dcmd.seek_step = 1'b1;
        end else begin
          dcmd.sweep_seg_init = 1'b1;
          state_nxt           = S_SEG;
        end
      end
      S_SEG: begin
        dcmd.seg_wr     = 1'b1;
        dcmd.sweep_step = 1'b1;
        if (stat.seg_last) begin
          state_nxt = S_DONE;
        end
      end
      S_ALL: begin
        dcmd.all_wr     = 1'b1;
        dcmd.sweep_step = 1'b1;
        if (stat.all_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          dcmd.finish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
